[hdl/dfpe_pkg.sv]
// Shared types and constants for the DShot frame pulse encoder.
`default_nettype none
package dfpe_pkg;

    localparam int THR_W   = 11;
    localparam int FRAME_W = 16;
    localparam int BIT_T_W = 14;
    localparam int TICK_W  = 15;
    localparam int IDX_W   = 5;
    localparam int CFG_A_W = 3;

    // Descriptor index of the trailing pause
    localparam logic [IDX_W-1:0] PAUSE_IDX = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_ONE_LOW   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_PAUSE     = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_SLOW      = 3'd5;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // Timing registers as seen by the serializer
    typedef struct packed {
        logic [BIT_T_W-1:0] zero_high;
        logic [BIT_T_W-1:0] zero_low;
        logic [BIT_T_W-1:0] one_high;
        logic [BIT_T_W-1:0] one_low;
        logic [TICK_W-1:0]  pause;
        logic               slow;
    } t_cfg;

    // One frame offered across a valid/ready boundary
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_frame_xfer;

    // Serializer status
    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } t_back_stat;

    // Build the 16-bit frame: throttle, telemetry bit zero, XOR checksum
    function automatic logic [FRAME_W-1:0] frame_word(input logic [THR_W-1:0] thr);
        logic [11:0] word;
        logic [3:0]  csum;
        word = {thr, 1'b0};
        csum = (word[3:0] ^ word[7:4] ^ word[11:8]) & NIBBLE_MASK;
        return {word, csum};
    endfunction

endpackage
`default_nettype wire

[hdl/dshot_frame_pulse_encoder.sv]
// Top level of the DShot frame pulse encoder: config registers, front, queue, serializer.
`default_nettype none
// Each accepted throttle value becomes a 16-bit DShot frame (telemetry bit zero,
// XOR nibble checksum) and is played out as 17 pulse descriptors, MSB first:
// 16 high/low pairs and a final low pause flagged with o_last. The output
// channel carries one descriptor per cycle unless the sink stalls; the
// serializer is the throughput limit. An accepted value goes through the front
// stage, the queue and the serializer frame register to the output register.
// Up to three further throttle values are held (front stage plus a
// two-frame queue) while a frame plays out, so frames follow back to back.
// Timing registers are read live by the serializer; write them only when the
// block is idle. Indexes 6 and 7 are ignored.
module dshot_frame_pulse_encoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [dfpe_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  wire logic [dfpe_pkg::TICK_W-1:0]   i_cfg_wr_data,
    // Throttle input
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [dfpe_pkg::THR_W-1:0]    i_throttle,
    // Descriptor output
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_first_level,
    output logic [dfpe_pkg::TICK_W-1:0]        o_first_ticks,
    output logic                               o_second_level,
    output logic [dfpe_pkg::TICK_W-1:0]        o_second_ticks,
    output logic                               o_last
);
    import dfpe_pkg::*;

    t_cfg        r_cfg;
    t_frame_xfer push;
    t_frame_xfer head;
    t_back_stat  stat;
    logic        push_ready;
    logic        pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= BIT_T_W'(50);
            r_cfg.zero_low  <= BIT_T_W'(83);
            r_cfg.one_high  <= BIT_T_W'(100);
            r_cfg.one_low   <= BIT_T_W'(33);
            r_cfg.pause     <= TICK_W'(2000);
            r_cfg.slow      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_wr_data[BIT_T_W-1:0];
                REG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_wr_data[BIT_T_W-1:0];
                REG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_wr_data[BIT_T_W-1:0];
                REG_ONE_LOW:   r_cfg.one_low   <= i_cfg_wr_data[BIT_T_W-1:0];
                REG_PAUSE:     r_cfg.pause     <= i_cfg_wr_data;
                REG_SLOW:      r_cfg.slow      <= i_cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    dfpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_throttle   (i_throttle),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    dfpe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    dfpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .o_pop          (pop),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_last         (o_last)
    );

    // Descriptor index never runs past the pause
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> (stat.idx <= PAUSE_IDX))
        else $error("serializer index beyond pause");

    // Serializer goes idle only right after loading the pause descriptor
    a_idle_after_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(stat.busy) |-> (o_valid && o_last))
        else $error("serializer stopped mid-frame");

    // Every descriptor that is not the pause is a high bit pulse
    a_bit_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_first_level)
        else $error("bit descriptor with low first level");

endmodule
`default_nettype wire

[hdl/dfpe_front.sv]
// Front end: accepts throttle values and forms checksummed frames.
`default_nettype none
module dfpe_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [dfpe_pkg::THR_W-1:0] i_throttle,
    output dfpe_pkg::t_frame_xfer          o_push,
    input  wire logic                      i_push_ready
);
    import dfpe_pkg::*;

    logic               r_valid;
    logic [FRAME_W-1:0] r_frame;
    logic               n_valid;

    // Stage frees up when empty or when its frame moves to the queue
    assign o_ready = !r_valid || i_push_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Frame word computed on the transfer
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frame <= frame_word(i_throttle);
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.frame = r_frame;

endmodule
`default_nettype wire

[hdl/dfpe_queue.sv]
// Two-entry frame queue between front end and serializer.
`default_nettype none
module dfpe_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dfpe_pkg::t_frame_xfer i_push,
    output logic                      o_push_ready,
    output dfpe_pkg::t_frame_xfer     o_head,
    input  wire logic                 i_pop
);
    import dfpe_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;
    localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

    logic [FRAME_W-1:0] r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_FULL);
    assign push         = i_push.valid && o_push_ready;
    assign pop          = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.frame = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.frame;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/dfpe_back.sv]
// Serializer: turns each frame into 16 bit descriptors and a pause descriptor.
`default_nettype none
module dfpe_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dfpe_pkg::t_cfg             i_cfg,
    input  wire dfpe_pkg::t_frame_xfer      i_head,
    output logic                            o_pop,
    output dfpe_pkg::t_back_stat            o_stat,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_first_level,
    output logic [dfpe_pkg::TICK_W-1:0]     o_first_ticks,
    output logic                            o_second_level,
    output logic [dfpe_pkg::TICK_W-1:0]     o_second_ticks,
    output logic                            o_last
);
    import dfpe_pkg::*;

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [FRAME_W-1:0] r_frame;
    logic               r_out_valid;
    logic               r_first_level;
    logic [TICK_W-1:0]  r_first_ticks;
    logic [TICK_W-1:0]  r_second_ticks;
    logic               r_last;

    logic               advance;
    logic               emit;
    logic               fin;
    logic [BIT_T_W-1:0] hi_sel;
    logic [BIT_T_W-1:0] lo_sel;
    logic [TICK_W-1:0]  hi_ticks;
    logic [TICK_W-1:0]  lo_ticks;

    // Output register moves when empty or taken downstream
    assign advance = !r_out_valid || i_ready;
    assign emit    = advance && r_busy;
    assign fin     = emit && (r_idx == PAUSE_IDX);
    assign o_pop   = i_head.valid && (!r_busy || fin);

    // Bit timing, doubled in slow mode
    assign hi_sel   = r_frame[FRAME_W-1] ? i_cfg.one_high : i_cfg.zero_high;
    assign lo_sel   = r_frame[FRAME_W-1] ? i_cfg.one_low  : i_cfg.zero_low;
    assign hi_ticks = i_cfg.slow ? {hi_sel, 1'b0} : {1'b0, hi_sel};
    assign lo_ticks = i_cfg.slow ? {lo_sel, 1'b0} : {1'b0, lo_sel};

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (advance) begin
                r_out_valid <= r_busy;
            end
        end
    end

    // Frame shift register, MSB first
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_head.frame;
        end else if (emit) begin
            r_frame <= {r_frame[FRAME_W-2:0], 1'b0};
        end
    end

    // Descriptor output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (fin) begin
                r_first_level  <= 1'b0;
                r_first_ticks  <= i_cfg.pause;
                r_second_ticks <= '0;
                r_last         <= 1'b1;
            end else begin
                r_first_level  <= 1'b1;
                r_first_ticks  <= hi_ticks;
                r_second_ticks <= lo_ticks;
                r_last         <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_level  = r_first_level;
    assign o_first_ticks  = r_first_ticks;
    assign o_second_level = 1'b0;
    assign o_second_ticks = r_second_ticks;
    assign o_last         = r_last;
    assign o_stat.busy    = r_busy;
    assign o_stat.idx     = r_idx;

endmodule
`default_nettype wire
